// ----- src/b64d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and helper functions of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Default depth of the record queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Alphabet bounds and special characters
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SLASH   = 8'h2f;

    // Sextet offsets of the lower-case and digit ranges
    localparam logic [5:0] OFS_LOWER = 6'd26;
    localparam logic [5:0] OFS_DIGIT = 6'd52;
    localparam logic [5:0] SX_PLUS   = 6'd62;
    localparam logic [5:0] SX_SLASH  = 6'd63;

    // Byte counts of a record
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_FULL = 2'd3;

    // Classified character
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    // One queued record: up to three bytes of a group
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            last;
    } t_record;

    // Map a character to its sextet; ok is low outside the alphabet
    function automatic t_sextet sextet_of(input logic [7:0] ch);
        t_sextet    r;
        logic [7:0] d;
        r.ok  = 1'b1;
        r.val = '0;
        d     = '0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            d     = ch - CH_UPPER_A;
            r.val = d[5:0];
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            d     = ch - CH_LOWER_A;
            r.val = d[5:0] + OFS_LOWER;
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            d     = ch - CH_DIGIT_0;
            r.val = d[5:0] + OFS_DIGIT;
        end else if (ch == CH_PLUS) begin
            r.val = SX_PLUS;
        end else if (ch == CH_SLASH) begin
            r.val = SX_SLASH;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // Three bytes from four sextets
    function automatic logic [2:0][7:0] group_bytes(input logic [5:0] s0,
                                                    input logic [5:0] s1,
                                                    input logic [5:0] s2,
                                                    input logic [5:0] s3);
        logic [2:0][7:0] b;
        b[0] = {s0, s1[5:4]};
        b[1] = {s1[3:0], s2[5:2]};
        b[2] = {s2[1:0], s3};
        return b;
    endfunction

endpackage

// ----- src/b64d_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them and builds per-group byte records.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_text_char,
    input  logic              i_final_char,
    output logic              o_push,
    output b64d_pkg::t_record o_record
);
    import b64d_pkg::*;

    logic [5:0] r_buf [3];
    logic [5:0] n_buf [3];
    logic [1:0] r_fill, n_fill;
    logic       r_stopped, n_stopped;
    logic       w_buf_we;
    t_sextet    w_sx;
    t_record    w_rec;

    assign w_sx = sextet_of(i_text_char);

    // Buffer with the current sextet merged in at the fill position
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_buf[i] = (r_fill == i[1:0]) ? w_sx.val : r_buf[i];
        end
    end

    // Group state update and record build
    always_comb begin
        n_fill      = r_fill;
        n_stopped   = r_stopped;
        w_buf_we    = 1'b0;
        w_rec.count = CNT_NONE;
        w_rec.bytes = group_bytes(r_buf[0], r_buf[1], r_buf[2], w_sx.val);
        w_rec.last  = i_final_char;
        if (!r_stopped) begin
            if (!w_sx.ok) begin
                // terminator: flush partial group
                w_rec.count = (r_fill == CNT_NONE) ? CNT_NONE : r_fill - 2'd1;
                w_rec.bytes = group_bytes(r_buf[0], r_buf[1], r_buf[2], 6'd0);
                n_stopped   = 1'b1;
                n_fill      = '0;
            end else if (r_fill == CNT_FULL) begin
                w_rec.count = CNT_FULL;
                n_fill      = '0;
            end else begin
                w_buf_we = 1'b1;
                n_fill   = r_fill + 2'd1;
                if (i_final_char) begin
                    // end of message flushes the group including this sextet
                    w_rec.count = r_fill;
                    w_rec.bytes = group_bytes(n_buf[0], n_buf[1], n_buf[2], 6'd0);
                end
            end
        end
        if (i_final_char) begin
            n_fill    = '0;
            n_stopped = 1'b0;
        end
    end

    assign o_push   = i_accept && ((w_rec.count != CNT_NONE) || i_final_char);
    assign o_record = w_rec;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_stopped <= 1'b0;
        end else if (i_accept) begin
            r_fill    <= n_fill;
            r_stopped <= n_stopped;
        end
    end

    // Sextet buffer, payload only
    always_ff @(posedge i_clk) begin
        if (i_accept && w_buf_we) begin
            r_buf <= n_buf;
        end
    end

endmodule

// ----- src/b64d_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_queue
// Small record FIFO that decouples the character front from the byte back.
// ----------------------------------------------------------------------------
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64d_pkg::t_record i_record,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_head_valid,
    output b64d_pkg::t_record o_head
);
    import b64d_pkg::*;

    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_record       r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full       = (r_count == FULL_CNT);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Record storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_record;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("record pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_head_valid))
        else $error("record popped from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

endmodule

// ----- src/b64d_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Serializes queued records into output beats through an output register.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  b64d_pkg::t_record i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_byte_present,
    output logic              o_message_end
);
    import b64d_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_present, n_present;
    logic       r_end, n_end;
    logic       w_load;
    logic       w_last_beat;

    assign w_load      = i_head_valid && (!r_valid || i_out_ready);
    assign w_last_beat = (i_head.count == CNT_NONE) || (r_idx == i_head.count - 2'd1);

    // Next beat from the head record
    always_comb begin
        if (i_head.count == CNT_NONE) begin
            // empty end-of-message marker
            n_byte    = '0;
            n_present = 1'b0;
            n_end     = 1'b1;
        end else begin
            n_byte    = i_head.bytes[r_idx];
            n_present = 1'b1;
            n_end     = i_head.last && w_last_beat;
        end
        n_idx = w_last_beat ? 2'd0 : r_idx + 2'd1;
    end

    assign o_pop = w_load && w_last_beat;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= n_idx;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte    <= n_byte;
            r_present <= n_present;
            r_end     <= n_end;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_out_byte     = r_byte;
    assign o_byte_present = r_present;
    assign o_message_end  = r_end;

    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_present) |-> r_end)
        else $error("empty beat without message end");

    a_empty_rec_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_head_valid && i_head.count == CNT_NONE) |-> i_head.last)
        else $error("empty record that does not end a message");

    a_idx_in_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_head_valid && i_head.count != CNT_NONE) |-> (r_idx < i_head.count))
        else $error("byte index beyond record");

endmodule

// ----- src/base64_stream_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Decodes standard-alphabet base64 text, one character per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one character and a flag
//   that marks the last character of a message. Output channel (o_out_valid /
//   i_out_ready) carries one decoded byte per beat; o_message_end marks the
//   last beat of a message, and a message that yields no byte gives one beat
//   with o_byte_present low.
//   Throughput: one character per cycle while the queue has room. A complete
//   group of four characters gives three output beats, drained one per cycle
//   by the back serializer while the receiver is ready. The first byte of a
//   record is registered in the queue, then in the output register.
//   When the receiver stalls, the output register holds its beat and the
//   record queue (QUEUE_DEPTH records) absorbs further groups; o_in_ready
//   drops only when the queue is full.
//   Reset clears group state, queue and output register; the block accepts
//   characters in the first cycle after reset.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_char,
    input  logic       i_final_char,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_present,
    output logic       o_message_end
);
    import b64d_pkg::*;

    logic    w_accept;
    logic    w_push;
    t_record w_push_rec;
    logic    w_full;
    logic    w_pop;
    logic    w_head_valid;
    t_record w_head;

    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && !w_full;

    // Character front
    b64d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_text_char  (i_text_char),
        .i_final_char (i_final_char),
        .o_push       (w_push),
        .o_record     (w_push_rec)
    );

    // Record queue
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_record     (w_push_rec),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // Byte back
    b64d_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (w_head_valid),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_message_end  (o_message_end)
    );

endmodule
